// File: design/hsml_pkg.sv
// hsml_pkg: shared types, character codes and helper functions for the
// hex stream memory loader; no dependencies
package hsml_pkg;

	localparam logic [7:0] CH_ADDR = 8'h40;
	localparam logic [7:0] CH_QUIT = 8'h71;
	localparam logic [3:0] NIBBLE_TEN = 4'hA;
	localparam logic [3:0] COUNT_MAX = 4'd15;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	typedef struct packed {
		logic        is_hex;
		logic [3:0]  nib;
	} hsml_digit_t;

	typedef struct packed {
		logic        valid;
		logic        kind;
		logic [31:0] addr;
		logic [31:0] data;
	} hsml_result_t;

	function automatic hsml_digit_t hex_value(input logic [7:0] ch);
		hsml_digit_t d;
		d.is_hex = 1'b1;
		d.nib = 4'd0;
		if (ch >= 8'h30 && ch <= 8'h39) begin
			d.nib = ch[3:0];
		end else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66)) begin
			d.nib = ch[3:0] - 4'd1 + NIBBLE_TEN;
		end else begin
			d.is_hex = 1'b0;
		end
		return d;
	endfunction

	function automatic logic [2:0] nib_ones(input logic [3:0] n);
		return {2'b00, n[0]} + {2'b00, n[1]} + {2'b00, n[2]} + {2'b00, n[3]};
	endfunction

	function automatic logic [5:0] popcount32(input logic [31:0] v);
		logic [5:0] sum;
		sum = 6'd0;
		for (int i = 0; i < 8; i++) begin
			sum = sum + {3'b000, nib_ones(v[4*i +: 4])};
		end
		return sum;
	endfunction

endpackage

// File: design/hsml_parser.sv
// hsml_parser: parse state (accumulator, digit count, address flag, write
// pointer, done flag) and per-character decode; uses hsml_pkg
module hsml_parser #(
	parameter int DIGITS_PER_WORD = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            ch,
	output hsml_pkg::hsml_result_t res
);
	import hsml_pkg::*;

	localparam logic [3:0] CNT_LIMIT = (DIGITS_PER_WORD < 15) ?
		4'(DIGITS_PER_WORD) : COUNT_MAX;

	logic [31:0] acc_q, acc_d;
	logic [3:0]  cnt_q, cnt_d;
	logic        addr_pend_q, addr_pend_d;
	logic [31:0] wptr_q, wptr_d;
	logic        done_q, done_d;
	hsml_digit_t dig;

	always_comb begin
		dig = hex_value(ch);
		acc_d = acc_q;
		cnt_d = cnt_q;
		addr_pend_d = addr_pend_q;
		wptr_d = wptr_q;
		done_d = done_q;
		res.valid = 1'b0;
		res.kind = KIND_WRITE;
		res.addr = wptr_q;
		res.data = acc_q;
		if (fire && !done_q) begin
			if (dig.is_hex) begin
				if (cnt_q < CNT_LIMIT) begin
					if (!cnt_q[3]) begin
						acc_d = acc_q | ({28'd0, dig.nib} << {~cnt_q[2:0], 2'b00});
					end
					cnt_d = cnt_q + 4'd1;
				end
			end else if (ch == CH_ADDR) begin
				addr_pend_d = 1'b1;
			end else if (ch == CH_QUIT) begin
				acc_d = 32'd0;
				cnt_d = 4'd0;
				addr_pend_d = 1'b0;
				done_d = 1'b1;
				res.valid = 1'b1;
				res.kind = KIND_DONE;
				res.addr = 32'd0;
				res.data = 32'd0;
			end else if (cnt_q != 4'd0) begin
				acc_d = 32'd0;
				cnt_d = 4'd0;
				if (addr_pend_q) begin
					wptr_d = acc_q;
					addr_pend_d = 1'b0;
				end else begin
					res.valid = 1'b1;
					wptr_d = wptr_q + 32'd4;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 32'd0;
			cnt_q <= 4'd0;
			addr_pend_q <= 1'b0;
			wptr_q <= 32'd0;
			done_q <= 1'b0;
		end else begin
			acc_q <= acc_d;
			cnt_q <= cnt_d;
			addr_pend_q <= addr_pend_d;
			wptr_q <= wptr_d;
			done_q <= done_d;
		end
	end

endmodule

// File: design/hsml_out_stage.sv
// hsml_out_stage: result register with popcount and output handshake;
// uses hsml_pkg
module hsml_out_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  hsml_pkg::hsml_result_t res,
	output logic                  advance,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  result_kind,
	output logic [31:0]           write_address,
	output logic [31:0]           write_data,
	output logic [5:0]            ones_count
);
	import hsml_pkg::*;

	logic valid_s2;

	assign advance = !valid_s2 || !out_stall;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= res.valid;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.valid) begin
			result_kind <= res.kind;
			write_address <= res.addr;
			write_data <= res.data;
			ones_count <= popcount32(res.data);
		end
	end

endmodule

// File: design/hex_stream_memory_loader_top.sv
// hex_stream_memory_loader_top: input register, parser and result register
// of the hex stream memory loader; uses hsml_pkg, hsml_parser, hsml_out_stage
//
// Usage: one received character per input beat (in_valid, in_stall, rx_char).
// Hex digits build a 32-bit word from the top nibble down; '@' marks the
// word as an address, any other character ends it, 'q' ends loading.
// A data word comes out as one output beat (result_kind 0) carrying the
// byte address, the word and its count of set bits; 'q' gives one beat of
// result_kind 1 with the other fields zero. Characters that end no word,
// address words and everything after 'q' give no beat.
// Path: each accepted character goes from the input register through the
// parse step, and its result into the result register, which drives the
// output. Throughput: one character per cycle while the receiver does not
// stall, set by the single parse step between the two registers.
// Reset clears the parse state: write pointer zero, no digits, not done.
// While the receiver stalls, the result holds; one more character can sit
// in the input register, then in_stall rises until the result is taken.
module hex_stream_memory_loader_top #(
	parameter int DIGITS_PER_WORD = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_char,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [31:0] write_address,
	output logic [31:0] write_data,
	output logic [5:0]  ones_count
);
	import hsml_pkg::*;

	logic         valid_s1;
	logic [7:0]   char_s1;
	logic         advance;
	logic         fire;
	hsml_result_t res;

	assign fire = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= rx_char;
		end
	end

	hsml_parser #(
		.DIGITS_PER_WORD(DIGITS_PER_WORD)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.ch     (char_s1),
		.res    (res)
	);

	hsml_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (fire),
		.res           (res),
		.advance       (advance),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_kind   (result_kind),
		.write_address (write_address),
		.write_data    (write_data),
		.ones_count    (ones_count)
	);

endmodule

// File: design/hsml_checker.sv
// hsml_checker: port-level assertions for the hex stream memory loader,
// bound to hex_stream_memory_loader_top; uses hsml_pkg
module hsml_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        result_kind,
	input logic [31:0] write_address,
	input logic [31:0] write_data,
	input logic [5:0]  ones_count
);
	import hsml_pkg::*;

	logic done_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_seen_q <= 1'b0;
		end else if (out_valid && !out_stall && result_kind == KIND_DONE) begin
			done_seen_q <= 1'b1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_kind)
			&& $stable(write_address) && $stable(write_data) && $stable(ones_count))
		else $error("stalled output beat changed");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_DONE |->
			write_address == 32'd0 && write_data == 32'd0 && ones_count == 6'd0)
		else $error("done beat carries nonzero fields");

	a_popcount: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $countones(write_data) == int'(ones_count))
		else $error("ones_count does not match write_data");

	a_quiet_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		done_seen_q |-> !out_valid)
		else $error("output beat after loading finished");

endmodule

bind hex_stream_memory_loader_top hsml_checker u_hsml_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.result_kind   (result_kind),
	.write_address (write_address),
	.write_data    (write_data),
	.ones_count    (ones_count)
);
